>>> hw/rtl/lrc_pkg.sv
`timescale 1ns / 1ps

package lrc_pkg;

   localparam int ENTRIES_DEF = 32;

   localparam int OP_W   = 2;
   localparam int DEV_W  = 8;
   localparam int BLK_W  = 32;
   localparam int SLOT_W = 5;
   localparam int TIME_W = 32;
   localparam int RC_W   = 8;
   localparam int ST_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_GET     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_PIN     = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK     = 2'd0,
      ST_NOFREE = 2'd1,
      ST_UNDER  = 2'd2,
      ST_OVER   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_TAIL,
      S_GET_UPD,
      S_SLOT_RD,
      S_SLOT_UPD
   } state_type;

   // one word of the entry memory
   typedef struct packed {
      logic [DEV_W-1:0]  dev;
      logic [BLK_W-1:0]  blk;
      logic [RC_W-1:0]   rc;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic busy;
      logic accept;
      logic scan_issue;
      logic get_upd;
      logic slot_rd;
      logic slot_upd;
   } ctrl_type;

endpackage

>>> hw/rtl/lru_refcount_block_cache_tags.sv
`timescale 1ns / 1ps
// channel  | ports                                               | flow
// request  | start, busy, req_operation, req_device,             | taken when start && !busy
//          | req_block_number, req_slot_in, req_now              |
// result   | rsp_valid, rsp_slot_out, rsp_hit, rsp_needs_read,   | one-cycle strobe
//          | rsp_status                                          |
//
// get: busy through the scan, tail and update states, then rsp_valid; the scan
//   reads one entry a cycle through the single read port of the entry ram into
//   the one tag and age compare unit.
// release / pin: busy through a read state, then a modify and write state, then rsp_valid.
// ignored requests: rsp_valid the next cycle, busy stays low.
// reset clears the per-entry valid bits at once; no clearing pass. rsp_valid can
//   never be held off, and a new request may be taken in the cycle it is shown.

module lru_refcount_block_cache_tags import lrc_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [DEV_W-1:0]  req_device,
   input  logic [BLK_W-1:0]  req_block_number,
   input  logic [SLOT_W-1:0] req_slot_in,
   input  logic [TIME_W-1:0] req_now,
   output logic              rsp_valid,
   output logic [SLOT_W-1:0] rsp_slot_out,
   output logic              rsp_hit,
   output logic              rsp_needs_read,
   output logic [ST_W-1:0]   rsp_status
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CMP_W = (IDX_W + 1 > SLOT_W) ? IDX_W + 1 : SLOT_W;
   localparam int ENT_W = $bits(entry_type);
   localparam logic [RC_W-1:0] RC_MAX = {RC_W{1'b1}};
   localparam logic [RC_W-1:0] RC_ONE = RC_W'(1);

   ctrl_type ctrl;

   op_type            op_ff;
   logic [DEV_W-1:0]  dev_ff;
   logic [BLK_W-1:0]  blk_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [TIME_W-1:0] now_ff;

   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             eval_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [IDX_W-1:0] slot_idx;
   logic [IDX_W-1:0] rd_addr;
   logic             last;

   logic req_is_get;
   logic req_is_skip;
   logic req_in_range;

   logic [ENTRIES-1:0] present_ff;
   logic [ENTRIES-1:0] loaded_ff;
   logic [ENTRIES-1:0] touched_ff;

   logic [ENT_W-1:0] ram_rdata;
   entry_type        rd_raw;
   entry_type        rd_entry;
   logic             rd_present;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   entry_type         wr_data;
   logic              set_tag;

   logic              hit;
   logic [IDX_W-1:0]  hit_idx;
   logic [RC_W-1:0]   hit_rc;
   logic [TIME_W-1:0] hit_stamp;
   logic              vic_found;
   logic [IDX_W-1:0]  vic_idx;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic              rsp_rd_ff, rsp_rd_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic [RC_W-1:0]   rc_dec;

   assign req_in_range = CMP_W'(req_slot_in) < CMP_W'(ENTRIES);
   assign req_is_get   = (op_type'(req_operation) == OP_GET);
   assign req_is_skip  = !req_is_get &&
                         ((op_type'(req_operation) == OP_NONE) || !req_in_range);

   assign last     = (cnt_ff == IDX_W'(ENTRIES - 1));
   assign slot_idx = IDX_W'(slot_ff);
   assign rd_addr  = ctrl.slot_rd ? slot_idx : cnt_ff;

   lrc_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .is_get  (req_is_get),
      .is_skip (req_is_skip),
      .last    (last),
      .ctrl    (ctrl)
   );

   lrc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // entries never written read as count zero and time zero
   always_comb begin
      rd_raw         = entry_type'(ram_rdata);
      rd_entry       = rd_raw;
      rd_present     = present_ff[rd_idx_ff];
      if (!touched_ff[rd_idx_ff]) begin
         rd_entry.rc    = '0;
         rd_entry.stamp = '0;
      end
   end

   lrc_scan #(
      .ENTRIES (ENTRIES)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .clr       (ctrl.accept),
      .eval      (eval_ff),
      .idx       (rd_idx_ff),
      .present   (rd_present),
      .entry     (rd_entry),
      .req_dev   (dev_ff),
      .req_blk   (blk_ff),
      .hit       (hit),
      .hit_idx   (hit_idx),
      .hit_rc    (hit_rc),
      .hit_stamp (hit_stamp),
      .vic_found (vic_found),
      .vic_idx   (vic_idx)
   );

   assign rc_dec = rd_entry.rc - RC_ONE;

   always_comb begin
      wr_en         = 1'b0;
      wr_idx        = slot_idx;
      wr_data       = rd_entry;
      set_tag       = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_rd_in     = rsp_rd_ff;
      rsp_status_in = rsp_status_ff;
      priority if (ctrl.accept && req_is_skip) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = req_slot_in;
         rsp_hit_in    = 1'b0;
         rsp_rd_in     = 1'b0;
         rsp_status_in = ST_OK;
      end else if (ctrl.get_upd) begin
         rsp_valid_in = 1'b1;
         priority if (hit) begin
            rsp_slot_in = SLOT_W'(hit_idx);
            rsp_hit_in  = 1'b1;
            if (hit_rc == RC_MAX) begin
               rsp_rd_in     = 1'b0;
               rsp_status_in = ST_OVER;
            end else begin
               wr_en         = 1'b1;
               wr_idx        = hit_idx;
               wr_data       = '{dev: dev_ff, blk: blk_ff, rc: hit_rc + RC_ONE,
                                 stamp: hit_stamp};
               set_tag       = 1'b1;
               rsp_rd_in     = !loaded_ff[hit_idx];
               rsp_status_in = ST_OK;
            end
         end else if (vic_found) begin
            wr_en         = 1'b1;
            wr_idx        = vic_idx;
            wr_data       = '{dev: dev_ff, blk: blk_ff, rc: RC_ONE, stamp: now_ff};
            set_tag       = 1'b1;
            rsp_slot_in   = SLOT_W'(vic_idx);
            rsp_hit_in    = 1'b0;
            rsp_rd_in     = 1'b1;
            rsp_status_in = ST_OK;
         end else begin
            rsp_slot_in   = '0;
            rsp_hit_in    = 1'b0;
            rsp_rd_in     = 1'b0;
            rsp_status_in = ST_NOFREE;
         end
      end else if (ctrl.slot_upd) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = slot_ff;
         rsp_hit_in    = 1'b0;
         rsp_rd_in     = 1'b0;
         rsp_status_in = ST_OK;
         if (op_ff == OP_RELEASE) begin
            if (rd_entry.rc == '0) begin
               rsp_status_in = ST_UNDER;
            end else begin
               wr_en      = 1'b1;
               wr_data.rc = rc_dec;
               // stamp only when the last reference goes away
               if (rc_dec == '0) begin
                  wr_data.stamp = now_ff;
               end
            end
         end else begin
            if (rd_entry.rc == RC_MAX) begin
               rsp_status_in = ST_OVER;
            end else begin
               wr_en      = 1'b1;
               wr_data.rc = rd_entry.rc + RC_ONE;
            end
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      priority if (ctrl.accept)   cnt_in = '0;
      else if (ctrl.scan_issue)   cnt_in = cnt_ff + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         op_ff   <= op_type'(req_operation);
         dev_ff  <= req_device;
         blk_ff  <= req_block_number;
         slot_ff <= req_slot_in;
         now_ff  <= req_now;
      end
      cnt_ff        <= cnt_in;
      rd_idx_ff     <= rd_addr;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_rd_ff     <= rsp_rd_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         present_ff   <= '0;
         loaded_ff    <= '0;
         touched_ff   <= '0;
      end else begin
         eval_ff      <= ctrl.scan_issue;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            touched_ff[wr_idx] <= 1'b1;
         end
         if (set_tag) begin
            present_ff[wr_idx] <= 1'b1;
            loaded_ff[wr_idx]  <= 1'b1;
         end
      end
   end

   assign busy           = ctrl.busy;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_out   = rsp_slot_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_needs_read = rsp_rd_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

>>> hw/rtl/lrc_ram.sv
`timescale 1ns / 1ps

module lrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/lrc_scan.sv
`timescale 1ns / 1ps

module lrc_scan import lrc_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clr,
   input  logic                       eval,
   input  logic [$clog2(ENTRIES)-1:0] idx,
   input  logic                       present,
   input  entry_type                  entry,
   input  logic [DEV_W-1:0]           req_dev,
   input  logic [BLK_W-1:0]           req_blk,
   output logic                       hit,
   output logic [$clog2(ENTRIES)-1:0] hit_idx,
   output logic [RC_W-1:0]            hit_rc,
   output logic [TIME_W-1:0]          hit_stamp,
   output logic                       vic_found,
   output logic [$clog2(ENTRIES)-1:0] vic_idx
);

   localparam int IDX_W = $clog2(ENTRIES);

   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [RC_W-1:0]   hit_rc_ff, hit_rc_in;
   logic [TIME_W-1:0] hit_stamp_ff, hit_stamp_in;
   logic              vic_ff, vic_in;
   logic [IDX_W-1:0]  vic_idx_ff, vic_idx_in;
   logic [TIME_W-1:0] oldest_ff, oldest_in;
   logic              match;
   logic              older;

   // one tag compare and one age compare per entry
   assign match = present && (entry.dev == req_dev) && (entry.blk == req_blk);
   assign older = (entry.rc == '0) && (!vic_ff || (entry.stamp < oldest_ff));

   always_comb begin
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rc_in    = hit_rc_ff;
      hit_stamp_in = hit_stamp_ff;
      vic_in       = vic_ff;
      vic_idx_in   = vic_idx_ff;
      oldest_in    = oldest_ff;
      priority if (clr) begin
         hit_in = 1'b0;
         vic_in = 1'b0;
      end else if (eval) begin
         // lowest index wins, so only the first match is kept
         if (match && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = idx;
            hit_rc_in    = entry.rc;
            hit_stamp_in = entry.stamp;
         end
         if (older) begin
            vic_in     = 1'b1;
            vic_idx_in = idx;
            oldest_in  = entry.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
         vic_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
         vic_ff <= vic_in;
      end
      hit_idx_ff   <= hit_idx_in;
      hit_rc_ff    <= hit_rc_in;
      hit_stamp_ff <= hit_stamp_in;
      vic_idx_ff   <= vic_idx_in;
      oldest_ff    <= oldest_in;
   end

   assign hit       = hit_ff;
   assign hit_idx   = hit_idx_ff;
   assign hit_rc    = hit_rc_ff;
   assign hit_stamp = hit_stamp_ff;
   assign vic_found = vic_ff;
   assign vic_idx   = vic_idx_ff;

endmodule

>>> hw/rtl/lrc_ctrl.sv
`timescale 1ns / 1ps

module lrc_ctrl import lrc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     is_get,
   input  logic     is_skip,
   input  logic     last,
   output ctrl_type ctrl
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               priority if (is_get) state_in = S_SCAN;
               else if (is_skip)    state_in = S_IDLE;
               else                 state_in = S_SLOT_RD;
            end
         end
         S_SCAN: begin
            if (last) state_in = S_TAIL;
         end
         S_TAIL:     state_in = S_GET_UPD;
         S_GET_UPD:  state_in = S_IDLE;
         S_SLOT_RD:  state_in = S_SLOT_UPD;
         S_SLOT_UPD: state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctrl            = '0;
      ctrl.busy       = (state_ff != S_IDLE);
      ctrl.accept     = (state_ff == S_IDLE) && start;
      ctrl.scan_issue = (state_ff == S_SCAN);
      ctrl.get_upd    = (state_ff == S_GET_UPD);
      ctrl.slot_rd    = (state_ff == S_SLOT_RD);
      ctrl.slot_upd   = (state_ff == S_SLOT_UPD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/lrc_check.sv
`timescale 1ns / 1ps

module lrc_check import lrc_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [OP_W-1:0]   req_operation,
   input logic [SLOT_W-1:0] req_slot_in,
   input logic              rsp_valid,
   input logic [SLOT_W-1:0] rsp_slot_out,
   input logic              rsp_hit,
   input logic              rsp_needs_read,
   input logic [ST_W-1:0]   rsp_status
);

   localparam int CMP_W = ($clog2(ENTRIES) + 1 > SLOT_W) ? $clog2(ENTRIES) + 1 : SLOT_W;

   logic accept;
   logic in_range;

   assign accept   = start && !busy;
   assign in_range = CMP_W'(req_slot_in) < CMP_W'(ENTRIES);

   // results only show once the engine has gone back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_get_latency: assert property (@(posedge clock) disable iff (reset)
      accept && (req_operation == OP_GET) |-> ##(ENTRIES + 3) rsp_valid)
      else $error("get result not on time");

   a_slot_latency: assert property (@(posedge clock) disable iff (reset)
      accept && in_range && ((req_operation == OP_RELEASE) || (req_operation == OP_PIN))
      |-> ##3 rsp_valid)
      else $error("release or pin result not on time");

   a_ignored: assert property (@(posedge clock) disable iff (reset)
      accept && (req_operation != OP_GET) && (!in_range || (req_operation == OP_NONE))
      |=> rsp_valid && (rsp_status == ST_OK) && !rsp_hit && !rsp_needs_read)
      else $error("ignored request answered wrongly");

   a_nofree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NOFREE)
      |-> (rsp_slot_out == '0) && !rsp_hit && !rsp_needs_read)
      else $error("no-free result carries slot or flags");

endmodule

bind lru_refcount_block_cache_tags lrc_check #(.ENTRIES(ENTRIES)) u_check (.*);
